>>> hw/rtl/gbcs_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the gyro bias calibrate and scale block
package gbcs_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int RATE_W     = 17;
	localparam int SETTLE_W   = 10;
	localparam int PHASE_W    = 11;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [SETTLE_W-1:0] SETTLE_RESET = 10'd19;

	// register word index taken from paddr above the byte offset
	localparam logic REG_SETTLE = 1'b0;

	// rate = round(|c| * 128 / 115): n = |c|*128 + 57, then n / 115 by reciprocal
	localparam int MAG_W       = 16;
	localparam int SCALE_UP    = 7;
	localparam int N_W         = 23;
	localparam logic [N_W-1:0] ROUND_BIAS = 23'd57;
	localparam int MUL_W       = 24;
	localparam logic [MUL_W-1:0] SCALE_MUL = 24'd9336886;
	localparam int SCALE_SHIFT = 30;
	localparam int PROD_W      = N_W + MUL_W;

	// offset divide: a reciprocal product step, then a saturate and sign step
	localparam int DIV_CYCLES  = 2;

	typedef enum logic [1:0] {
		ST_CAL,
		ST_DIV,
		ST_RUN
	} cal_state_t;

	typedef struct packed {
		logic acc_en;
		logic div_start;
		logic div_step;
		logic div_last;
	} lane_ctl_t;

	typedef struct packed {
		logic in_open;
		logic run;
	} cal_status_t;

endpackage

>>> hw/rtl/gbcs_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for gyro samples and scaled results
interface gbcs_in_if;
	logic valid;
	logic ready;
	logic signed [gbcs_pkg::SAMPLE_W-1:0] sample_x;
	logic signed [gbcs_pkg::SAMPLE_W-1:0] sample_y;
	logic signed [gbcs_pkg::SAMPLE_W-1:0] sample_z;

	modport source (output valid, sample_x, sample_y, sample_z, input ready);
	modport sink (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

interface gbcs_out_if;
	logic valid;
	logic ready;
	logic signed [gbcs_pkg::SAMPLE_W-1:0] corrected_x;
	logic signed [gbcs_pkg::SAMPLE_W-1:0] corrected_y;
	logic signed [gbcs_pkg::SAMPLE_W-1:0] corrected_z;
	logic signed [gbcs_pkg::RATE_W-1:0] rate_x;
	logic signed [gbcs_pkg::RATE_W-1:0] rate_y;
	logic signed [gbcs_pkg::RATE_W-1:0] rate_z;

	modport source (output valid, corrected_x, corrected_y, corrected_z,
		rate_x, rate_y, rate_z, input ready);
	modport sink (input valid, corrected_x, corrected_y, corrected_z,
		rate_x, rate_y, rate_z, output ready);
endinterface

>>> hw/rtl/gyro_bias_calibrate_and_scale.sv
`timescale 1ns / 1ps
// top level: three axis lanes, calibration sequencer and merged output register
//
//  channel   dir   protocol       beat contents
//  sample    in    valid/ready    sample_x, sample_y, sample_z
//  result    out   valid/ready    corrected_x/y/z, rate_x/y/z
//  apb       in    psel/penable   settle_samples at byte address 0
//
// one beat per cycle unless stalled; a result passes the s1, s2 and output registers after its sample beat
// a dropped calibration beat leaves no trace in the pipeline
// the first beat past the averaging window starts the offset divide, which holds
// sample.ready low while it runs a reciprocal multiply, then saturate and sign
// stalls on result collapse bubbles stage by stage back to sample.ready
// reset clears sequencer, accumulators, offsets and valid bits at once
module gyro_bias_calibrate_and_scale #(
	parameter int AVERAGE_SAMPLES = 100
) (
	input  logic                                clk,
	input  logic                                arst_n,
	gbcs_in_if.sink                             sample,
	gbcs_out_if.source                          result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [gbcs_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [gbcs_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [gbcs_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	gbcs_pkg::lane_ctl_t    ctl;
	gbcs_pkg::cal_status_t  status;
	logic                   accept;
	logic                   en1, en2, en3;
	logic                   v1_q, v2_q, v3_q;

	logic signed [gbcs_pkg::SAMPLE_W-1:0] cx_s2, cy_s2, cz_s2;
	logic signed [gbcs_pkg::RATE_W-1:0]   rx_s2, ry_s2, rz_s2;

	assign en3 = !v3_q || result.ready;
	assign en2 = !v2_q || en3;
	assign en1 = !v1_q || en2;
	assign sample.ready = en1 && status.in_open;
	assign accept = sample.valid && sample.ready;

	gbcs_ctrl #(
		.AVERAGE_SAMPLES(AVERAGE_SAMPLES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.ctl     (ctl),
		.status  (status)
	);

	gbcs_lane #(.AVERAGE_SAMPLES(AVERAGE_SAMPLES)) u_lane_x (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .en1(en1), .en2(en2),
		.sample(sample.sample_x), .corrected_s2(cx_s2), .rate_s2(rx_s2)
	);

	gbcs_lane #(.AVERAGE_SAMPLES(AVERAGE_SAMPLES)) u_lane_y (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .en1(en1), .en2(en2),
		.sample(sample.sample_y), .corrected_s2(cy_s2), .rate_s2(ry_s2)
	);

	gbcs_lane #(.AVERAGE_SAMPLES(AVERAGE_SAMPLES)) u_lane_z (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .en1(en1), .en2(en2),
		.sample(sample.sample_z), .corrected_s2(cz_s2), .rate_s2(rz_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= accept && status.run;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en3) begin
				v3_q <= v2_q;
			end
		end
	end

	// merged output register across the three lanes
	always_ff @(posedge clk) begin
		if (en3) begin
			result.corrected_x <= cx_s2;
			result.corrected_y <= cy_s2;
			result.corrected_z <= cz_s2;
			result.rate_x <= rx_s2;
			result.rate_y <= ry_s2;
			result.rate_z <= rz_s2;
		end
	end

	assign result.valid = v3_q;

endmodule

>>> hw/rtl/gbcs_lane.sv
`timescale 1ns / 1ps
// one axis: bias accumulator, reciprocal offset divide, correction and scaling stages
module gbcs_lane #(
	parameter int AVERAGE_SAMPLES = 100
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  gbcs_pkg::lane_ctl_t                   ctl,
	input  logic                                  en1,
	input  logic                                  en2,
	input  logic signed [gbcs_pkg::SAMPLE_W-1:0]  sample,
	output logic signed [gbcs_pkg::SAMPLE_W-1:0]  corrected_s2,
	output logic signed [gbcs_pkg::RATE_W-1:0]    rate_s2
);

	// a settle write during calibration can stretch the window, so the sum
	// must hold every beat up to the largest settle count plus the average length
	localparam int MAX_TERMS = (1 << gbcs_pkg::SETTLE_W) - 1 + AVERAGE_SAMPLES;
	localparam int SUM_W = gbcs_pkg::SAMPLE_W + $clog2(MAX_TERMS);
	// |sum| / AVERAGE_SAMPLES as (|sum| * RECIP) >> RECIP_SHIFT, exact below 2^SUM_W
	localparam int DIV_L = $clog2(AVERAGE_SAMPLES);
	localparam int RECIP_SHIFT = SUM_W + DIV_L;
	localparam int RECIP_W = SUM_W + 1;
	localparam logic [63:0] RECIP_POW = 64'd1 << RECIP_SHIFT;
	localparam logic [63:0] RECIP_FULL =
		(RECIP_POW + 64'(AVERAGE_SAMPLES) - 64'd1) / 64'(AVERAGE_SAMPLES);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
	localparam int OFS_PROD_W = SUM_W + RECIP_W;
	localparam int OFS_Q_W = OFS_PROD_W - RECIP_SHIFT;
	localparam logic [OFS_Q_W-1:0] POS_LIM = OFS_Q_W'((1 << (gbcs_pkg::SAMPLE_W-1)) - 1);
	localparam logic [OFS_Q_W-1:0] NEG_LIM = OFS_Q_W'(1 << (gbcs_pkg::SAMPLE_W-1));

	logic signed [SUM_W-1:0]                 sum_q;
	logic signed [gbcs_pkg::SAMPLE_W-1:0]    offset_q;
	logic [SUM_W-1:0]                        mag_q;
	logic                                    neg_q;
	logic [OFS_PROD_W-1:0]                   ofs_prod_q;

	logic [SUM_W-1:0]                        sum_mag;
	logic [OFS_Q_W-1:0]                      ofs_quot;
	logic [OFS_Q_W-1:0]                      ofs_lim;
	logic [OFS_Q_W-1:0]                      ofs_sat;
	logic [gbcs_pkg::SAMPLE_W-1:0]           ofs_mag;

	logic signed [gbcs_pkg::SAMPLE_W:0]      diff;
	logic signed [gbcs_pkg::SAMPLE_W-1:0]    corr;
	logic [gbcs_pkg::MAG_W-1:0]              mag;
	logic [gbcs_pkg::N_W-1:0]                n_val;

	logic signed [gbcs_pkg::SAMPLE_W-1:0]    corrected_s1;
	logic [gbcs_pkg::N_W-1:0]                n_s1;
	logic                                    neg_s1;
	logic [gbcs_pkg::PROD_W-1:0]             prod_s2;
	logic                                    neg_s2;
	logic [gbcs_pkg::RATE_W-2:0]             quot;

	// truncating divide on the magnitude, clamped to the signed 16-bit range
	always_comb begin
		sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		ofs_quot = ofs_prod_q[OFS_PROD_W-1:RECIP_SHIFT];
		ofs_lim = neg_q ? NEG_LIM : POS_LIM;
		ofs_sat = (ofs_quot > ofs_lim) ? ofs_lim : ofs_quot;
		ofs_mag = ofs_sat[gbcs_pkg::SAMPLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			offset_q <= '0;
		end else begin
			if (ctl.acc_en) begin
				sum_q <= sum_q + SUM_W'(sample);
			end
			if (ctl.div_last) begin
				offset_q <= neg_q ? -signed'(ofs_mag) : signed'(ofs_mag);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.div_start) begin
			mag_q <= sum_mag;
			neg_q <= sum_q[SUM_W-1];
		end
		if (ctl.div_step) begin
			ofs_prod_q <= OFS_PROD_W'(mag_q) * OFS_PROD_W'(RECIP);
		end
	end

	// subtract offset and saturate, then form the rounding numerator
	always_comb begin
		diff = (gbcs_pkg::SAMPLE_W+1)'(sample) - (gbcs_pkg::SAMPLE_W+1)'(offset_q);
		if (diff[gbcs_pkg::SAMPLE_W] != diff[gbcs_pkg::SAMPLE_W-1]) begin
			corr = diff[gbcs_pkg::SAMPLE_W] ? {1'b1, {(gbcs_pkg::SAMPLE_W-1){1'b0}}}
				: {1'b0, {(gbcs_pkg::SAMPLE_W-1){1'b1}}};
		end else begin
			corr = diff[gbcs_pkg::SAMPLE_W-1:0];
		end
		mag = corr[gbcs_pkg::SAMPLE_W-1] ? gbcs_pkg::MAG_W'(-corr) : gbcs_pkg::MAG_W'(corr);
		n_val = {mag, {gbcs_pkg::SCALE_UP{1'b0}}} | gbcs_pkg::ROUND_BIAS;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			corrected_s1 <= corr;
			n_s1 <= n_val;
			neg_s1 <= corr[gbcs_pkg::SAMPLE_W-1];
		end
		if (en2) begin
			corrected_s2 <= corrected_s1;
			prod_s2 <= gbcs_pkg::PROD_W'(n_s1) * gbcs_pkg::PROD_W'(gbcs_pkg::SCALE_MUL);
			neg_s2 <= neg_s1;
		end
	end

	always_comb begin
		quot = prod_s2[gbcs_pkg::SCALE_SHIFT +: (gbcs_pkg::RATE_W-1)];
		rate_s2 = neg_s2 ? -signed'({1'b0, quot}) : signed'({1'b0, quot});
	end

endmodule

>>> hw/rtl/gbcs_ctrl.sv
`timescale 1ns / 1ps
// calibration sequencer and settle_samples register on the apb port
module gbcs_ctrl #(
	parameter int AVERAGE_SAMPLES = 100
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [gbcs_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [gbcs_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [gbcs_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output gbcs_pkg::lane_ctl_t                 ctl,
	output gbcs_pkg::cal_status_t               status
);

	localparam int CNT_W = $clog2(gbcs_pkg::DIV_CYCLES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(gbcs_pkg::DIV_CYCLES - 1);
	localparam logic [gbcs_pkg::PHASE_W-1:0] AVG_LEN = gbcs_pkg::PHASE_W'(AVERAGE_SAMPLES);

	gbcs_pkg::cal_state_t                state_q, state_d;
	logic [gbcs_pkg::PHASE_W-1:0]        phase_q, phase_d, phase_inc, win_end;
	logic [CNT_W-1:0]                    cnt_q, cnt_d;
	logic [gbcs_pkg::SETTLE_W-1:0]       settle_q;
	logic                                reg_sel;

	assign reg_sel = (paddr[gbcs_pkg::APB_ADDR_W-1] == gbcs_pkg::REG_SETTLE);
	assign pready = 1'b1;
	assign prdata = reg_sel ? gbcs_pkg::APB_DATA_W'(settle_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= gbcs_pkg::SETTLE_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			settle_q <= pwdata[gbcs_pkg::SETTLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbcs_pkg::ST_CAL;
			phase_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			cnt_q <= cnt_d;
		end
	end

	assign phase_inc = phase_q + gbcs_pkg::PHASE_W'(1);
	assign win_end = gbcs_pkg::PHASE_W'(settle_q) + AVG_LEN;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cnt_d = cnt_q;
		ctl = '0;
		unique case (state_q)
			gbcs_pkg::ST_CAL: begin
				if (accept) begin
					phase_d = phase_inc;
					if (phase_inc <= gbcs_pkg::PHASE_W'(settle_q)) begin
						// still settling, beat dropped
					end else if (phase_inc <= win_end) begin
						ctl.acc_en = 1'b1;
					end else begin
						ctl.div_start = 1'b1;
						cnt_d = '0;
						state_d = gbcs_pkg::ST_DIV;
					end
				end
			end
			gbcs_pkg::ST_DIV: begin
				ctl.div_step = 1'b1;
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					ctl.div_last = 1'b1;
					state_d = gbcs_pkg::ST_RUN;
				end
			end
			gbcs_pkg::ST_RUN: begin
			end
			default: begin
				state_d = gbcs_pkg::ST_CAL;
			end
		endcase
		status.in_open = (state_q != gbcs_pkg::ST_DIV);
		status.run = (state_q == gbcs_pkg::ST_RUN);
	end

endmodule

>>> hw/rtl/gbcs_checker.sv
`timescale 1ns / 1ps
// port-level checks for the gyro bias calibrate and scale block, with its bind
module gbcs_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [gbcs_pkg::SAMPLE_W-1:0] corrected_x,
	input logic signed [gbcs_pkg::RATE_W-1:0]   rate_x,
	input logic                                 psel,
	input logic                                 penable,
	input logic                                 pwrite,
	input logic [gbcs_pkg::APB_ADDR_W-1:0]      paddr,
	input logic [gbcs_pkg::APB_DATA_W-1:0]      pwdata,
	input logic [gbcs_pkg::APB_DATA_W-1:0]      prdata
);

	// a held result beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(corrected_x) && $stable(rate_x))
		else $error("result payload changed while stalled");

	// scaled rate keeps the sign and zero of the corrected value
	a_rate_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rate_x[gbcs_pkg::RATE_W-1] == corrected_x[gbcs_pkg::SAMPLE_W-1])
			&& ((rate_x == '0) == (corrected_x == '0)))
		else $error("rate_x disagrees with corrected_x");

	a_reg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && !paddr[gbcs_pkg::APB_ADDR_W-1]
		|=> paddr[gbcs_pkg::APB_ADDR_W-1]
			|| (prdata[gbcs_pkg::SETTLE_W-1:0] == $past(pwdata[gbcs_pkg::SETTLE_W-1:0])))
		else $error("settle_samples readback mismatch");

	a_unmapped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		paddr[gbcs_pkg::APB_ADDR_W-1] |-> prdata == '0)
		else $error("unmapped register reads nonzero");

endmodule

bind gyro_bias_calibrate_and_scale gbcs_checker u_gbcs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.corrected_x (result.corrected_x),
	.rate_x      (result.rate_x),
	.psel        (psel),
	.penable     (penable),
	.pwrite      (pwrite),
	.paddr       (paddr),
	.pwdata      (pwdata),
	.prdata      (prdata)
);
